FILE: hw/rtl/punrank_pkg.sv
// Shared types, constants and the factorial table for the permutation unranker.
package punrank_pkg;

   localparam int MAX_N   = 12;
   localparam int SIZE_W  = 4;
   localparam int RANK_W  = 29;
   localparam int POS_W   = 4;
   localparam int VAL_W   = 4;
   localparam int QUOT_W  = 4;
   localparam int STEP_W  = 2;
   localparam int REQ_W   = 40;
   localparam int RSP_W   = 8;

   typedef struct packed {
      logic start;
      logic div_step;
      logic scan_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic input_err;
      logic div_last;
      logic found;
      logic value_last;
      logic out_free;
      logic emit_last;
   } sts_type;

   // k! for k in 0..MAX_N; codes above the table give zero
   function automatic logic [RANK_W-1:0] fact(input logic [SIZE_W-1:0] k);
      logic [RANK_W-1:0] f;
      unique case (k)
         4'd0:    f = 29'd1;
         4'd1:    f = 29'd1;
         4'd2:    f = 29'd2;
         4'd3:    f = 29'd6;
         4'd4:    f = 29'd24;
         4'd5:    f = 29'd120;
         4'd6:    f = 29'd720;
         4'd7:    f = 29'd5040;
         4'd8:    f = 29'd40320;
         4'd9:    f = 29'd362880;
         4'd10:   f = 29'd3628800;
         4'd11:   f = 29'd39916800;
         4'd12:   f = 29'd479001600;
         default: f = '0;
      endcase
      return f;
   endfunction

endpackage

FILE: hw/rtl/punrank_ctrl.sv
// Sequencing state machine for the permutation unranker.
module punrank_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  punrank_pkg::sts_type sts,
   output punrank_pkg::cmd_type cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_DIV   = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready    = (state_ff == ST_IDLE);
   assign cmd.start     = req_tvalid && (state_ff == ST_IDLE);
   assign cmd.div_step  = (state_ff == ST_DIV);
   assign cmd.scan_step = (state_ff == ST_SCAN);
   assign cmd.out_load  = (state_ff == ST_EMIT) && sts.out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = sts.input_err ? ST_EMIT : ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_last) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.found) state_in = sts.value_last ? ST_EMIT : ST_DIV;
         end
         ST_EMIT: begin
            // hand back to idle once the final result sits in the output register
            if (sts.out_free && sts.emit_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/punrank_dp.sv
// Datapath: input latch, shared quotient unit, slot scan and output register.
module punrank_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [punrank_pkg::REQ_W-1:0]         req_tdata,
   input  logic                                  rsp_tready,
   output logic                                  rsp_tvalid,
   output logic [punrank_pkg::RSP_W-1:0]         rsp_tdata,
   output logic                                  rsp_tlast,
   output logic [0:0]                            rsp_tuser,
   input  punrank_pkg::cmd_type                  cmd,
   output punrank_pkg::sts_type                  sts
);

   localparam int RW = punrank_pkg::RANK_W;
   localparam int DW = punrank_pkg::RANK_W + 4;

   logic [punrank_pkg::SIZE_W-1:0] size_ff;
   logic [RW-1:0]                  rem_ff, rem_in;
   logic [punrank_pkg::VAL_W-1:0]  value_ff;
   logic [punrank_pkg::STEP_W-1:0] step_ff;
   logic [punrank_pkg::QUOT_W-1:0] quot_ff, quot_in;
   logic [punrank_pkg::POS_W-1:0]  scan_ff;
   logic [punrank_pkg::POS_W-1:0]  emit_ff;
   logic [punrank_pkg::MAX_N-1:0]  full_ff;
   logic [punrank_pkg::VAL_W-1:0]  slot_value [punrank_pkg::MAX_N];
   logic                           err_ff;

   logic                           out_valid_ff;
   logic [punrank_pkg::POS_W-1:0]  out_pos_ff;
   logic [punrank_pkg::VAL_W-1:0]  out_val_ff;
   logic                           out_last_ff;
   logic                           out_err_ff;

   logic [RW-1:0]                  divisor;
   logic [DW-1:0]                  trial;
   logic                           scan_ok;
   logic                           slot_empty;
   logic                           emit_last;

   assign divisor = punrank_pkg::fact(size_ff - value_ff - 4'd1);
   assign trial   = {4'd0, rem_ff} - ({4'd0, divisor} << step_ff);

   assign scan_ok    = (scan_ff < 4'(punrank_pkg::MAX_N));
   assign slot_empty = scan_ok && !full_ff[scan_ff];
   assign emit_last  = err_ff || (emit_ff == size_ff - 4'd1);

   assign sts.input_err  = (size_ff == '0) || (size_ff > 4'(punrank_pkg::MAX_N))
                           || (rem_ff >= punrank_pkg::fact(size_ff));
   assign sts.div_last   = (step_ff == '0);
   assign sts.found      = slot_empty && (quot_ff == '0);
   assign sts.value_last = (value_ff == size_ff - 4'd1);
   assign sts.out_free   = !out_valid_ff || rsp_tready;
   assign sts.emit_last  = emit_last;

   // one restoring step per cycle, quotient bits from the top down
   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (cmd.div_step) begin
         quot_in = {quot_ff[punrank_pkg::QUOT_W-2:0], !trial[DW-1]};
         if (!trial[DW-1]) rem_in = trial[RW-1:0];
      end else if (cmd.scan_step && slot_empty && (quot_ff != '0)) begin
         quot_in = quot_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff      <= '0;
         value_ff     <= '0;
         rem_ff       <= '0;
         step_ff      <= '1;
         scan_ff      <= '0;
         emit_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.start) begin
            size_ff  <= req_tdata[punrank_pkg::SIZE_W-1:0];
            rem_ff   <= req_tdata[punrank_pkg::SIZE_W +: RW];
            full_ff  <= '0;
            value_ff <= '0;
            emit_ff  <= '0;
         end else begin
            rem_ff <= rem_in;
         end
         quot_ff <= quot_in;
         step_ff <= cmd.div_step ? step_ff - 2'd1 : '1;
         scan_ff <= (cmd.scan_step && !sts.found) ? scan_ff + 4'd1 : '0;
         if (cmd.scan_step && sts.found) begin
            full_ff[scan_ff]    <= 1'b1;
            slot_value[scan_ff] <= value_ff;
            value_ff            <= value_ff + 4'd1;
         end
         if (cmd.out_load) begin
            emit_ff <= emit_ff + 4'd1;
         end
         out_valid_ff <= cmd.out_load || (out_valid_ff && !rsp_tready);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         err_ff <= 1'b0;
      end else if (cmd.div_step == 1'b0 && cmd.scan_step == 1'b0 && emit_ff == '0
                   && value_ff == '0 && sts.input_err) begin
         // latch the range check while no value has been placed yet
         err_ff <= 1'b1;
      end
      if (cmd.out_load) begin
         out_pos_ff  <= err_ff ? '0 : emit_ff;
         out_val_ff  <= err_ff ? '0 : slot_value[emit_ff];
         out_last_ff <= emit_last;
         out_err_ff  <= err_ff;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = {out_val_ff, out_pos_ff};
   assign rsp_tlast    = out_last_ff;
   assign rsp_tuser[0] = out_err_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!out_valid_ff || rsp_tready))
      else $error("result loaded over a pending transfer");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_step && !err_ff) |-> (scan_ff < size_ff))
      else $error("slot scan ran past the permutation size");

   a_slots_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (full_ff == '0))
      else $error("slot flags not cleared for a new item");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && err_ff) |-> emit_last)
      else $error("error result not marked last");

endmodule

FILE: hw/rtl/permutation_unrank_top.sv
// Top level of the permutation unranker: controller plus datapath.
//
//  channel | direction | tdata (low bit up)                       | tuser / tlast
//  req     | in        | perm_size[3:0], rank[32:4], zero pad     | -
//  rsp     | out       | position[3:0], value[7:4]                | rank_error / last
//
// An item of size n passes through intake and range check, then per value 4 quotient steps
// plus a scan that stops at the chosen slot, then emits its results in position order.
// A bad size or a rank of size factorial or more gives one result, flagged as rank_error.
// Reset is synchronous and returns the controller to idle with no result pending.
// The last result waits in the output register while the next item is taken;
// a stall on rsp holds the emitting sequence.
module permutation_unrank_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [punrank_pkg::REQ_W-1:0]      req_tdata,   // perm_size, rank
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [punrank_pkg::RSP_W-1:0]      rsp_tdata,   // position, value
   output logic                               rsp_tlast,
   output logic [0:0]                         rsp_tuser    // rank_error
);

   punrank_pkg::cmd_type cmd;
   punrank_pkg::sts_type sts;

   punrank_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   punrank_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the permutation unranker: stream stimulus and permutation checks.
module tb_top;

   localparam int IDLE_LIMIT   = 4000;
   localparam int TAIL_CYCLES  = 300;
   localparam int RANDOM_ITEMS = 350;

   typedef logic [punrank_pkg::SIZE_W-1:0] size_type;
   typedef logic [punrank_pkg::RANK_W-1:0] rank_type;

   function automatic longint unsigned factorial(input int k);
      longint unsigned f;
      f = 1;
      for (int j = 2; j <= k; j++) f *= j;
      return f;
   endfunction

   class perm_scoreboard;
      typedef struct packed {
         logic [punrank_pkg::POS_W-1:0] pos;
         logic [punrank_pkg::VAL_W-1:0] val;
         logic                          last;
         logic                          err;
      } slot_result_type;

      slot_result_type awaited[$];
      int              errors;

      function new();
         errors = 0;
      endfunction

      task report_mismatch(input string msg);
         errors++;
         $display("mismatch @%0t: %s", $realtime, msg);
      endtask

      // Place values 0,1,2,... into the q-th empty slot, q taken from the factoradic digits
      function void note_request(input size_type n, input rank_type r);
         logic [punrank_pkg::VAL_W-1:0] slot_val [punrank_pkg::MAX_N];
         bit                            taken    [punrank_pkg::MAX_N];
         longint unsigned               rest, divisor, q;
         slot_result_type               res;
         if (n == 0 || n > punrank_pkg::MAX_N || r >= factorial(int'(n))) begin
            res = '{pos: '0, val: '0, last: 1'b1, err: 1'b1};
            awaited.push_back(res);
            return;
         end
         foreach (taken[k]) taken[k] = 1'b0;
         foreach (slot_val[k]) slot_val[k] = '0;
         rest    = 64'(r);
         divisor = factorial(int'(n));
         for (int v = 0; v < n; v++) begin
            divisor = divisor / (n - v);
            q       = rest / divisor;
            rest    = rest % divisor;
            for (int k = 0; k < n; k++) begin
               if (!taken[k]) begin
                  if (q == 0) begin
                     taken[k]    = 1'b1;
                     slot_val[k] = v[punrank_pkg::VAL_W-1:0];
                     break;
                  end
                  q--;
               end
            end
         end
         for (int k = 0; k < n; k++) begin
            res = '{pos: k[punrank_pkg::POS_W-1:0], val: slot_val[k],
                    last: (k == n - 1), err: 1'b0};
            awaited.push_back(res);
         end
      endfunction

      task check_result(input logic [punrank_pkg::POS_W-1:0] pos,
                        input logic [punrank_pkg::VAL_W-1:0] val,
                        input logic last, input logic err);
         slot_result_type exp;
         if (awaited.size() == 0) begin
            report_mismatch($sformatf("unexpected result pos=%0d val=%0d last=%0b err=%0b",
                                      pos, val, last, err));
            return;
         end
         exp = awaited.pop_front();
         if (pos !== exp.pos)
            report_mismatch($sformatf("position %0d, want %0d", pos, exp.pos));
         if (val !== exp.val)
            report_mismatch($sformatf("value %0d at position %0d, want %0d",
                                      val, exp.pos, exp.val));
         if (last !== exp.last)
            report_mismatch($sformatf("last %0b at position %0d, want %0b",
                                      last, exp.pos, exp.last));
         if (err !== exp.err)
            report_mismatch($sformatf("rank_error %0b at position %0d, want %0b",
                                      err, exp.pos, exp.err));
      endtask

      task close_out();
         while (awaited.size() != 0) begin
            void'(awaited.pop_front());
            report_mismatch("result never arrived");
         end
      endtask
   endclass

   logic                              clock;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [punrank_pkg::REQ_W-1:0]     req_tdata  = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [punrank_pkg::RSP_W-1:0]     rsp_tdata;
   logic                              rsp_tlast;
   logic [0:0]                        rsp_tuser;

   perm_scoreboard perm_sb = new();
   bit             calm = 1'b0;
   int             idle_count = 0;
   int             stall_left = 0;

   permutation_unrank_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // mostly short gaps, now and then a long one; none while calm
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // keep tvalid high across back-to-back transfers; drop it only for a gap
   task automatic send_item(input size_type n, input rank_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(punrank_pkg::REQ_W - punrank_pkg::SIZE_W - punrank_pkg::RANK_W){1'b0}},
                     r, n};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_random(input int count);
      size_type        n;
      rank_type        r;
      int              roll;
      longint unsigned nfact;
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
         roll  = $urandom_range(0, 99);
         n     = size_type'($urandom_range(1, punrank_pkg::MAX_N));
         nfact = factorial(int'(n));
         if (roll < 85) begin
            r = rank_type'($urandom_range(0, 32'(nfact - 1)));
         end else if (roll < 93) begin
            r = rank_type'($urandom_range(32'(nfact), (1 << punrank_pkg::RANK_W) - 1));
         end else begin
            // sizes out of range: 0 and 13..15
            n = size_type'($urandom_range(punrank_pkg::MAX_N + 1, punrank_pkg::MAX_N + 4));
            r = rank_type'($urandom());
         end
         send_item(n, r);
      end
   endtask

   // monitor: note accepted requests and check accepted results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            perm_sb.note_request(req_tdata[punrank_pkg::SIZE_W-1:0],
               req_tdata[punrank_pkg::SIZE_W+punrank_pkg::RANK_W-1:punrank_pkg::SIZE_W]);
         if (rsp_tvalid && rsp_tready)
            perm_sb.check_result(rsp_tdata[punrank_pkg::POS_W-1:0],
               rsp_tdata[punrank_pkg::POS_W+punrank_pkg::VAL_W-1:punrank_pkg::POS_W],
               rsp_tlast, rsp_tuser[0]);
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_count <= 0;
      end else begin
         idle_count <= idle_count + 1;
         if (idle_count >= IDLE_LIMIT) begin
            $display("[permutation_unrank_top] ERROR");
            $finish;
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes of size and rank, every small permutation, error cases
      send_item(4'd1, 29'd0);
      send_item(4'd1, 29'd1);
      send_item(4'd2, 29'd0);
      send_item(4'd2, 29'd1);
      for (int k = 0; k < 6; k++) send_item(4'd3, rank_type'(k));
      send_item(4'd3, 29'd6);
      send_item(4'd5, 29'd119);
      send_item(4'd5, 29'd120);
      send_item(4'd11, rank_type'(factorial(11) - 1));
      send_item(4'd12, 29'd0);
      send_item(4'd12, rank_type'(factorial(12) - 1));
      send_item(4'd12, rank_type'(factorial(12)));
      send_item(4'd12, {punrank_pkg::RANK_W{1'b1}});
      send_item(4'd0, 29'd0);
      send_item(4'd13, 29'd0);
      send_item(4'd15, {punrank_pkg::RANK_W{1'b1}});

      send_random(RANDOM_ITEMS);
      req_tvalid <= 1'b0;
      calm = 1'b0;

      while (perm_sb.awaited.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      perm_sb.close_out();
      if (perm_sb.errors == 0) begin
         $display("[permutation_unrank_top] OK");
      end else begin
         $display("[permutation_unrank_top] ERROR");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/punrank_pkg.sv
hw/rtl/punrank_ctrl.sv
hw/rtl/punrank_dp.sv
hw/rtl/permutation_unrank_top.sv
test/tb_top.sv
